// ===== rtl/bmd_pkg.sv =====
`default_nettype none

package bmd_pkg;

    localparam int unsigned ORDER_W   = 5;
    localparam logic [ORDER_W-1:0] ORDER_RST = 5'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDC,
        ST_LDC,
        ST_CMP,
        ST_PUSH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/block_median_decimator_top.sv =====
`default_nettype none
// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: sample_value; tlast: end_of_signal
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: median_value
// cfg       | in  | i_cfg_valid / o_cfg_ready     | i_cfg_data: window_order
//
// A sample that does not close a window leaves the sequencer idle and ready for the next sample.
// Closing a window of order k runs a rank search on one comparator that reads
// the window RAM one entry per cycle.
// The synchronous reset clears the count and the sequencer and sets the order to 3.
// Input is held off during the search; a result waiting in the output
// register blocks only the load of the next result.

module block_median_decimator_top
    import bmd_pkg::*;
#(
    parameter int unsigned MAX_ORDER    = 16,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_value, rest zero
    input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // end_of_signal
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [SAMPLE_WIDTH-1:0] median_value, rest zero
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [ORDER_W-1:0]                   i_cfg_data
);

    localparam int unsigned DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int unsigned AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int unsigned CW = $clog2(MAX_ORDER + 1);
    localparam int unsigned OW = (CW > ORDER_W) ? CW : ORDER_W;

    logic [SAMPLE_WIDTH-1:0] mem [MAX_ORDER];

    t_state                  r_state, n_state;
    logic [ORDER_W-1:0]      r_order;
    logic [CW-1:0]           r_fill, n_fill;
    logic [AW-1:0]           r_i, n_i;
    logic [AW-1:0]           r_jd, n_jd;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [SAMPLE_WIDTH-1:0] r_cand, n_cand;
    logic [SAMPLE_WIDTH-1:0] r_rd;
    logic [SAMPLE_WIDTH-1:0] r_med;
    logic                    r_ov, n_ov;

    logic [CW-1:0]           k;
    logic [OW-1:0]           order_ext;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic                    accept;
    logic                    less;
    logic [CW-1:0]           rank;
    logic [CW-1:0]           fill_inc;
    logic                    last_j;
    logic                    push_ok;

    assign order_ext = OW'(r_order);
    always_comb begin
        if (r_order == '0) begin
            k = CW'(1);
        end else if (order_ext > OW'(MAX_ORDER)) begin
            k = CW'(MAX_ORDER);
        end else begin
            k = CW'(order_ext);
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = DW'(r_med);

    assign less     = ($signed(r_rd) < $signed(r_cand))
                      || ((r_rd == r_cand) && (r_jd < r_i));
    assign rank     = r_cnt + CW'(less);
    assign last_j   = (CW'(r_jd) == (k - CW'(1)));
    assign fill_inc = (r_fill < CW'(MAX_ORDER)) ? (r_fill + CW'(1)) : r_fill;
    assign push_ok  = !r_ov || m_axis_tready;

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        wr_en         = 1'b0;
        rd_addr       = r_i;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                wr_en         = accept && (r_fill < CW'(MAX_ORDER));
            end
            ST_RDC:  rd_addr = r_i;
            ST_LDC:  rd_addr = '0;
            ST_CMP:  rd_addr = r_jd + AW'(1);
            ST_PUSH: rd_addr = r_i;
            default: rd_addr = r_i;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_i     = r_i;
        n_jd    = r_jd;
        n_cnt   = r_cnt;
        n_cand  = r_cand;
        n_ov    = r_ov;
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (fill_inc >= k) begin
                        n_fill  = '0;
                        n_i     = '0;
                        n_state = ST_RDC;
                    end else begin
                        n_fill = fill_inc;
                    end
                    if (s_axis_tlast) begin
                        n_fill = '0;
                    end
                end
            end
            ST_RDC: begin
                n_state = ST_LDC;
            end
            ST_LDC: begin
                n_cand  = r_rd;
                n_jd    = '0;
                n_cnt   = '0;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_cnt = rank;
                n_jd  = r_jd + AW'(1);
                if (last_j) begin
                    if (rank == (k >> 1)) begin
                        n_state = ST_PUSH;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = ST_RDC;
                    end
                end
            end
            ST_PUSH: begin
                if (push_ok) begin
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_fill[AW-1:0]] <= s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_order <= ORDER_RST;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_order <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_jd   <= n_jd;
        r_cnt  <= n_cnt;
        r_cand <= n_cand;
        if (r_state == ST_PUSH && push_ok) begin
            r_med <= r_cand;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_ORDER))
        else $error("window count beyond depth");

    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (CW'(r_i) < k))
        else $error("candidate index ran past window");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (CW'(r_jd) < k))
        else $error("scan index ran past window");

    a_push_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && push_ok) |=> (r_ov && r_state == ST_IDLE))
        else $error("result not loaded");

    a_no_input_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken during search");

endmodule

`default_nettype wire
